FILE: rtl/core/fsh_pkg.sv
// Shared widths and types for the four-lane string hash.
// No dependencies; imported by every module of the block.
package fsh_pkg;

    localparam int UNIT_W    = 16;
    localparam int LANE_W    = 32;
    localparam int NUM_LANES = 4;
    localparam int PTR_W     = 2;
    localparam int HASH_W    = 64;

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [NUM_LANES-1:0] lane_set_t;

    // Final lane values of one string, handed to the combining stages.
    typedef struct packed {
        logic      valid;
        lane_set_t lanes;
    } fold_word_t;

endpackage

FILE: rtl/core/fsh_lanes.sv
// Input register, per-lane multiply-add and end-of-string snapshot.
// Depends on fsh_pkg.
module fsh_lanes
    import fsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [UNIT_W-1:0] code_unit,
    input  logic              has_char,
    input  logic              last,
    output fold_word_t        fold,
    input  logic              fold_take
);

    localparam logic [16:0] LANE_MULT = 17'h1003F;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [UNIT_W-1:0] unit_reg;
    logic              char_reg;
    logic              last_reg;
    lane_set_t         lanes_reg;
    lane_set_t         lanes_next;
    lane_set_t         lanes_upd;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic              fold_valid_reg;
    logic              fold_valid_next;
    lane_set_t         fold_lanes_reg;
    logic [48:0]       lane_prod;
    lane_t             lane_new;
    logic              fold_free;
    logic              in_go;
    logic              accept;

    assign fold_free  = !fold_valid_reg || fold_take;
    assign in_go      = in_valid_reg && (!last_reg || fold_free);
    assign item_stall = in_valid_reg && !in_go;
    assign accept     = item_valid && !item_stall;

    assign lane_prod = lanes_reg[ptr_reg] * LANE_MULT;
    assign lane_new  = lane_prod[LANE_W-1:0] + {{(LANE_W-UNIT_W){1'b0}}, unit_reg};

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            if (char_reg && ptr_reg == PTR_W'(k))
            begin
                lanes_upd[k] = lane_new;
            end
            else
            begin
                lanes_upd[k] = lanes_reg[k];
            end
        end
    end

    always_comb
    begin
        lanes_next = lanes_reg;
        ptr_next   = ptr_reg;
        if (in_go)
        begin
            if (last_reg)
            begin
                lanes_next = '0;
                ptr_next   = '0;
            end
            else
            begin
                lanes_next = lanes_upd;
                ptr_next   = char_reg ? ptr_reg + PTR_W'(1) : ptr_reg;
            end
        end
    end

    assign in_valid_next   = accept || (in_valid_reg && !in_go);
    assign fold_valid_next = (in_go && last_reg) || (fold_valid_reg && !fold_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            lanes_reg      <= '0;
            ptr_reg        <= '0;
            fold_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            lanes_reg      <= lanes_next;
            ptr_reg        <= ptr_next;
            fold_valid_reg <= fold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            unit_reg <= code_unit;
            char_reg <= has_char;
            last_reg <= last;
        end
        if (in_go && last_reg)
        begin
            fold_lanes_reg <= lanes_upd;
        end
    end

    assign fold.valid = fold_valid_reg;
    assign fold.lanes = fold_lanes_reg;

    // A finished string leaves all lanes and the pointer cleared.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && last_reg) |=> (ptr_reg == '0 && lanes_reg == '0))
        else $error("lanes not cleared after end of string");

    // A word without a character leaves the lane pointer alone.
    a_idle_keeps_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && !char_reg && !last_reg) |=> $stable(ptr_reg))
        else $error("lane pointer moved on an idle word");

    // A snapshot that is not taken is held unchanged.
    a_fold_held: assert property (@(posedge clk) disable iff (!rst_n)
        (fold_valid_reg && !fold_take) |=> (fold_valid_reg && $stable(fold_lanes_reg)))
        else $error("pending lane snapshot lost or changed");

endmodule

FILE: rtl/core/fsh_combine.sv
// Weighted combination of the four final lanes into the 64-bit hash.
// Depends on fsh_pkg; fed by fsh_lanes.
module fsh_combine
    import fsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fold_word_t        fold,
    output logic              fold_take,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [HASH_W-1:0] hash
);

    // Each weight of lanes 0 to 2 is split into small factors placed above or below bit 32; lane 3 has weight one.
    localparam logic [9:0] C0_HI = 10'd486;
    localparam logic [9:0] C0_LO = 10'd729;
    localparam logic [9:0] C1_HI = 10'd36;
    localparam logic [9:0] C1_LO = 10'd81;
    localparam logic [9:0] C2_LO = 10'd9;

    typedef logic [NUM_LANES-1:0][HASH_W-1:0] term_set_t;

    logic              term_valid_reg;
    logic              term_valid_next;
    term_set_t         term_reg;
    term_set_t         term_new;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [HASH_W-1:0] hash_reg;
    logic [41:0]       p0_hi;
    logic [41:0]       p0_lo;
    logic [41:0]       p1_hi;
    logic [41:0]       p1_lo;
    logic [41:0]       p2_lo;
    logic              out_ready;
    logic              out_load;
    logic              term_free;

    assign out_ready = !out_valid_reg || !result_stall;
    assign out_load  = term_valid_reg && out_ready;
    assign term_free = !term_valid_reg || out_load;
    assign fold_take = fold.valid && term_free;

    assign p0_hi = {10'b0, fold.lanes[0]} * {32'b0, C0_HI};
    assign p0_lo = {10'b0, fold.lanes[0]} * {32'b0, C0_LO};
    assign p1_hi = {10'b0, fold.lanes[1]} * {32'b0, C1_HI};
    assign p1_lo = {10'b0, fold.lanes[1]} * {32'b0, C1_LO};
    assign p2_lo = {10'b0, fold.lanes[2]} * {32'b0, C2_LO};

    assign term_new[0] = {p0_hi[31:0], 32'b0} - {22'b0, p0_lo};
    assign term_new[1] = {22'b0, p1_lo} - {p1_hi[31:0], 32'b0};
    assign term_new[2] = {fold.lanes[2][30:0], 33'b0} - {22'b0, p2_lo};
    assign term_new[3] = {32'b0, fold.lanes[3]};

    assign term_valid_next = fold_take || (term_valid_reg && !out_load);
    assign out_valid_next  = out_load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            term_valid_reg <= term_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_take)
        begin
            term_reg <= term_new;
        end
        if (out_load)
        begin
            hash_reg <= (term_reg[0] + term_reg[1]) + (term_reg[2] + term_reg[3]);
        end
    end

    assign result_valid = out_valid_reg;
    assign hash         = hash_reg;

    // Terms waiting on a full output register must not be overwritten.
    a_terms_held: assert property (@(posedge clk) disable iff (!rst_n)
        (term_valid_reg && !out_ready) |=> (term_valid_reg && $stable(term_reg)))
        else $error("pending hash terms lost or changed");

    // A snapshot is only taken when the term stage can hold it.
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        fold_take |-> (!term_valid_reg || out_load))
        else $error("snapshot taken into an occupied term stage");

    // A loaded hash always follows a valid term stage.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !term_valid_reg) |=> !out_valid_reg)
        else $error("result raised without terms");

endmodule

FILE: rtl/core/four_lane_string_hash_unit.sv
// Top level of the four-lane string hash: lane update and hash combining.
// Depends on fsh_pkg, fsh_lanes and fsh_combine.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------
//  item     | item_valid / item_stall     | code_unit, has_char, last
//  result   | result_valid / result_stall | hash
//
// One word is taken every cycle while the result side keeps moving.
// A string's last word passes the input register, lane snapshot, term stage and output register.
// The input register, lane stage, term stage and output register each
// hold one word, so a stalled result backs up through them before
// item_stall rises. Reset clears the lanes, the lane pointer and all
// stage valid flags.
module four_lane_string_hash_unit
    import fsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [UNIT_W-1:0] code_unit,
    input  logic              has_char,
    input  logic              last,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [HASH_W-1:0] hash
);

    fold_word_t fold;
    logic       fold_take;

    fsh_lanes u_lanes (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .code_unit  (code_unit),
        .has_char   (has_char),
        .last       (last),
        .fold       (fold),
        .fold_take  (fold_take)
    );

    fsh_combine u_combine (
        .clk          (clk),
        .rst_n        (rst_n),
        .fold         (fold),
        .fold_take    (fold_take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hash         (hash)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for four_lane_string_hash_unit: directed and random strings.
// Depends on fsh_pkg and the block's RTL; a built-in lane predictor checks every hash.
`timescale 1ns / 100ps

module tb;
    import fsh_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 250000;
    localparam int unsigned RANDOM_WORDS = 1300;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              has_char;
        logic              last;
    } str_word_t;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    logic [UNIT_W-1:0] code_unit;
    logic              has_char;
    logic              last;
    logic              result_valid;
    logic              result_stall;
    logic [HASH_W-1:0] hash;

    str_word_t         word_queue[$];
    logic [HASH_W-1:0] hash_queue[$];

    logic [LANE_W-1:0] lane_acc[NUM_LANES];
    logic [PTR_W-1:0]  lane_sel;

    logic              in_fire;
    logic              out_fire;
    logic              hold_on;
    logic              idle_on;
    int unsigned       send_wait;
    int unsigned       recv_wait;
    int unsigned       cycle_cnt;
    int unsigned       words_taken;
    int unsigned       hashes_checked;
    int unsigned       strings_queued;
    int unsigned       words_queued;
    int unsigned       hold_stalls;
    int unsigned       err_cnt;

    four_lane_string_hash_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .code_unit    (code_unit),
        .has_char     (has_char),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hash         (hash)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    assign idle_on = (cycle_cnt % 3000) < 2000;

    function automatic int unsigned pick_wait();
        return idle_on ? $urandom_range(0, 19) : 0;
    endfunction

    function automatic logic [UNIT_W-1:0] pick_unit();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return UNIT_W'($urandom_range(0, 65535));
    endfunction

    task automatic queue_word(input logic [UNIT_W-1:0] unit, input logic hc, input logic lst);
        word_queue.push_back('{unit: unit, has_char: hc, last: lst});
        if (hc || lst)
            words_queued++;
        if (lst)
            strings_queued++;
    endtask

    task automatic fold_unit(input str_word_t w);
        logic [HASH_W-1:0] sum;
        if (w.has_char)
        begin
            lane_acc[lane_sel] = lane_acc[lane_sel] * 32'h0001_003F + {16'h0, w.unit};
            lane_sel = lane_sel + 1'b1;
        end
        if (w.last)
        begin
            sum = 64'h0000_01E5_FFFF_FD27 * {32'h0, lane_acc[0]}
                + 64'hFFFF_FFDC_0000_0051 * {32'h0, lane_acc[1]}
                + 64'h0000_0001_FFFF_FFF7 * {32'h0, lane_acc[2]}
                + {32'h0, lane_acc[3]};
            hash_queue.push_back(sum);
            for (int i = 0; i < NUM_LANES; i++)
                lane_acc[i] = '0;
            lane_sel = '0;
        end
    endtask

    task automatic check_hash(input logic [HASH_W-1:0] got);
        logic [HASH_W-1:0] want;
        if (hash_queue.size() == 0)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("ERROR: unexpected hash %h at cycle %0d", got, cycle_cnt);
        end
        else
        begin
            want = hash_queue.pop_front();
            hashes_checked++;
            if (got !== want)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("ERROR: hash mismatch at cycle %0d: expected %h, got %h",
                             cycle_cnt, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end
        else
        begin
            cycle_cnt++;
            in_fire  <= item_valid && !item_stall;
            out_fire <= result_valid && !result_stall;
            if (hold_on && item_stall)
                hold_stalls++;
            if (item_valid && !item_stall)
            begin
                words_taken++;
                fold_unit('{unit: code_unit, has_char: has_char, last: last});
            end
            if (result_valid && !result_stall)
                check_hash(hash);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || in_fire))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                item_valid <= 1'b0;
            end
            else if (word_queue.size() > 0)
            begin
                str_word_t w;
                w = word_queue.pop_front();
                item_valid <= 1'b1;
                code_unit  <= w.unit;
                has_char   <= w.has_char;
                last       <= w.last;
                send_wait  = pick_wait();
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                recv_wait = pick_wait();
            if (hold_on || recv_wait > 0)
                result_stall <= 1'b1;
            else
                result_stall <= 1'b0;
            if (recv_wait > 0)
                recv_wait--;
        end
    end

    initial
    begin
        hold_on = 1'b0;
        @(posedge rst_n);
        while (words_taken < 150)
            @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
    end

    always @(posedge clk)
    begin
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d hashes outstanding",
                     cycle_cnt, hash_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int unsigned base;
        int unsigned len;
        int unsigned kind;
        bit          charless_end;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        code_unit    = '0;
        has_char     = 1'b0;
        last         = 1'b0;
        result_stall = 1'b0;
        in_fire      = 1'b0;
        out_fire     = 1'b0;
        send_wait    = 0;
        recv_wait    = 0;
        cycle_cnt    = 0;
        words_taken  = 0;
        hashes_checked = 0;
        strings_queued = 0;
        words_queued   = 0;
        hold_stalls    = 0;
        err_cnt        = 0;
        lane_sel       = '0;
        for (int i = 0; i < NUM_LANES; i++)
            lane_acc[i] = '0;

        // Directed strings: empty, ignored idle word, extremes, wrap and a charless end.
        queue_word(16'h0000, 1'b0, 1'b1);
        queue_word(16'h1234, 1'b0, 1'b0);
        queue_word(16'hFFFF, 1'b1, 1'b1);
        queue_word(16'h0000, 1'b1, 1'b1);
        queue_word(16'hFFFF, 1'b1, 1'b0);
        queue_word(16'h0000, 1'b1, 1'b0);
        queue_word(16'hFFFF, 1'b1, 1'b0);
        queue_word(16'h8000, 1'b1, 1'b0);
        queue_word(16'h0001, 1'b1, 1'b0);
        queue_word(16'hFFFF, 1'b1, 1'b1);
        queue_word(16'h5A5A, 1'b1, 1'b0);
        queue_word(16'hA5A5, 1'b1, 1'b0);
        queue_word(16'hFFFF, 1'b0, 1'b1);
        queue_word(16'h0000, 1'b0, 1'b1);
        for (int i = 0; i < 5; i++)
            queue_word(16'hFFFF, 1'b1, i == 4);

        base = words_queued;
        while (words_queued - base < RANDOM_WORDS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 3)
                queue_word(pick_unit(), 1'b0, 1'b1);
            else if (kind < 88)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                charless_end = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        queue_word(pick_unit(), 1'b0, 1'b0);
                    queue_word(pick_unit(), 1'b1, (i == len - 1) && !charless_end);
                end
                if (charless_end)
                    queue_word(pick_unit(), 1'b0, 1'b1);
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    queue_word(pick_unit(), 1'($urandom_range(0, 1)),
                               $urandom_range(0, 3) == 0);
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (word_queue.size() > 0 || item_valid)
            @(posedge clk);
        while (hash_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d words taken, %0d strings queued, %0d hashes checked.",
                 words_taken, strings_queued, hashes_checked);
        $display("Input stalled for %0d cycles during the long result hold-off; %0d errors.",
                 hold_stalls, err_cnt);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
